[hw/rtl/lir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared widths, register indexes, reset values and the lane request type.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int unsigned MAX_CHANNELS_DEF   = 4;
  localparam int unsigned SAMPLE_BITS_DEF    = 24;
  localparam int unsigned MAX_UPSAMPLE_DEF   = 64;
  localparam int unsigned FIELD_CHANNELS     = 4;

  localparam int unsigned RATE_W    = 19;
  localparam int unsigned PHASE_W   = 21;
  localparam int unsigned CHCNT_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE   = 2'd2;

  localparam logic [CHCNT_W-1:0] CHCNT_RESET = 3'd1;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 19'd48000;

  typedef struct packed {
    logic                      start;
    logic signed [PHASE_W-1:0] num;
    logic [RATE_W-1:0]         outr;
  } lane_req_t;

endpackage

[hw/rtl/lir_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler interpolation lane
// Computes prev + round((cur - prev) * num / outr) with saturation for one
// channel, using a registered multiply and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module lir_lane #(
  parameter int unsigned SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lir_pkg::lane_req_t            req_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_i,
  input  logic signed [SAMPLE_BITS-1:0] cur_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] res_o
);
  import lir_pkg::*;

  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = DIFF_W + PHASE_W;
  localparam int unsigned MAG_W  = PROD_W - 1;
  localparam int unsigned N_W    = MAG_W + 1;
  localparam int unsigned D_W    = RATE_W + 1;
  localparam int unsigned QB     = SAMPLE_BITS + 1;
  localparam int unsigned HI_W   = N_W - QB;
  localparam int unsigned IT_W   = $clog2(QB);
  localparam int unsigned SUM_W  = QB + 2;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(QB - 1);
  localparam logic signed [SUM_W-1:0] HI_LIM = {{(SUM_W-SAMPLE_BITS+1){1'b0}},
                                                {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] LO_LIM = ~HI_LIM;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MUL  = 3'd1;
  localparam logic [2:0] L_PREP = 3'd2;
  localparam logic [2:0] L_DIV  = 3'd3;
  localparam logic [2:0] L_FIN  = 3'd4;

  logic [2:0]                    st_q, st_d;
  logic signed [DIFF_W-1:0]      diff_q;
  logic signed [PHASE_W-1:0]     num_q;
  logic [RATE_W-1:0]             outr_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic                          neg_q, ovf_q;
  logic [D_W-1:0]                den_q, rem_q;
  logic [QB-1:0]                 low_q;
  logic [IT_W-1:0]               it_q;
  logic signed [SAMPLE_BITS-1:0] res_q;

  logic [PROD_W-1:0]        prod_abs;
  logic [MAG_W-1:0]         mag;
  logic [N_W-1:0]           numer;
  logic [D_W-1:0]           den;
  logic [HI_W-1:0]          hi;
  logic                     ovf;
  logic [D_W:0]             trial, trial_sub;
  logic                     ge;
  logic [QB-1:0]            qmag;
  logic signed [SUM_W-1:0]  qs, sum;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  always_comb begin
    prod_abs  = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    mag       = prod_abs[MAG_W-1:0];
    numer     = {mag, 1'b0} + N_W'(outr_q);
    den       = {outr_q, 1'b0};
    hi        = numer[N_W-1:QB];
    ovf       = hi >= HI_W'(den);
    trial     = {rem_q, low_q[QB-1]};
    trial_sub = trial - {1'b0, den_q};
    ge        = trial >= {1'b0, den_q};
    qmag      = ovf_q ? {QB{1'b1}} : low_q;
    qs        = neg_q ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    sum       = SUM_W'(prev_q) + qs;
    if (sum > HI_LIM) begin
      sat_val = HI_LIM[SAMPLE_BITS-1:0];
    end else if (sum < LO_LIM) begin
      sat_val = LO_LIM[SAMPLE_BITS-1:0];
    end else begin
      sat_val = sum[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      L_IDLE: begin
        if (req_i.start) st_d = L_MUL;
      end
      L_MUL:  st_d = L_PREP;
      L_PREP: st_d = L_DIV;
      L_DIV: begin
        if (it_q == IT_LAST) st_d = L_FIN;
      end
      L_FIN:  st_d = L_IDLE;
      default: st_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= L_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      L_IDLE: begin
        if (req_i.start) begin
          diff_q <= DIFF_W'(cur_i) - DIFF_W'(prev_i);
          num_q  <= req_i.num;
          outr_q <= req_i.outr;
          prev_q <= prev_i;
        end
      end
      L_MUL: begin
        prod_q <= diff_q * num_q;
      end
      L_PREP: begin
        neg_q <= prod_q[PROD_W-1];
        ovf_q <= ovf;
        den_q <= den;
        rem_q <= ovf ? '0 : hi[D_W-1:0];
        low_q <= numer[QB-1:0];
        it_q  <= '0;
      end
      L_DIV: begin
        rem_q <= ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
        low_q <= {low_q[QB-2:0], ge};
        it_q  <= it_q + 1'b1;
      end
      L_FIN: begin
        res_q <= sat_val;
      end
      default: begin
      end
    endcase
  end

  assign done_o = (st_q == L_IDLE);
  assign res_o  = res_q;

endmodule

[hw/rtl/linear_interp_resampler_unit.sv]
// An input request is taken only while idle. Each output frame then passes
// the check state, the lane multiply, prepare, bit-serial rounding divide and
// finish steps, and waits for a free output register; a check with no output
// position due closes the frame. Reset clears the previous frame, the phase,
// the output valid flag and restores the default configuration.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Sequences output positions with an exact rational phase, runs one lane per
// channel and merges the lane results into the output frame register.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit #(
  parameter int unsigned MAX_CHANNELS       = lir_pkg::MAX_CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS        = lir_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_UPSAMPLE_RATIO = lir_pkg::MAX_UPSAMPLE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lir_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lir_pkg::RATE_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   in_ch0_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_ch1_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_ch2_i,
  input  logic signed [SAMPLE_BITS-1:0]   in_ch3_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   out_ch0_o,
  output logic signed [SAMPLE_BITS-1:0]   out_ch1_o,
  output logic signed [SAMPLE_BITS-1:0]   out_ch2_o,
  output logic signed [SAMPLE_BITS-1:0]   out_ch3_o,
  output logic                            last_of_run_o
);
  import lir_pkg::*;

  localparam int unsigned NUM_LANES = (MAX_CHANNELS < FIELD_CHANNELS) ? MAX_CHANNELS
                                                                      : FIELD_CHANNELS;
  localparam int unsigned CNT_W = $clog2(MAX_UPSAMPLE_RATIO + 1);
  localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_UPSAMPLE_RATIO);
  localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(MAX_UPSAMPLE_RATIO - 1);
  localparam logic [CHCNT_W-1:0] NCH_MAX  = CHCNT_W'(NUM_LANES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [CHCNT_W-1:0] chcnt_q;
  logic [RATE_W-1:0]  inrate_q, outrate_q;

  logic [1:0]                    st_q, st_d;
  logic signed [PHASE_W-1:0]     phase_q;
  logic [CNT_W-1:0]              count_q;
  logic [RATE_W-1:0]             inr_q, outr_q;
  logic                          last_q;
  logic [FIELD_CHANNELS-1:0]     act_q;
  logic signed [SAMPLE_BITS-1:0] cur_q  [FIELD_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] prev_q [FIELD_CHANNELS];

  logic                          out_valid_q;
  logic                          out_last_q;
  logic signed [SAMPLE_BITS-1:0] out_ch_q [FIELD_CHANNELS];

  logic signed [SAMPLE_BITS-1:0] in_ch    [FIELD_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] lane_res [FIELD_CHANNELS];
  logic [FIELD_CHANNELS-1:0]     lane_done;
  logic [FIELD_CHANNELS-1:0]     act;
  logic [CHCNT_W-1:0]            nch;
  logic                          accept, due, load, phase_le0, next_le0;
  logic signed [PHASE_W-1:0]     inr_s, outr_s, d_next, d_fin;
  lane_req_t                     lane_req;

  assign in_ch[0] = in_ch0_i;
  assign in_ch[1] = in_ch1_i;
  assign in_ch[2] = in_ch2_i;
  assign in_ch[3] = in_ch3_i;

  always_comb begin
    if (chcnt_q == '0) begin
      nch = CHCNT_W'(1);
    end else if (chcnt_q > NCH_MAX) begin
      nch = NCH_MAX;
    end else begin
      nch = chcnt_q;
    end
    for (int c = 0; c < FIELD_CHANNELS; c++) begin
      act[c] = CHCNT_W'(c) < nch;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  assign inr_s     = $signed(PHASE_W'(inr_q));
  assign outr_s    = $signed(PHASE_W'(outr_q));
  assign d_next    = phase_q + inr_s;
  assign phase_le0 = phase_q[PHASE_W-1] || (phase_q == '0);
  assign next_le0  = d_next[PHASE_W-1] || (d_next == '0);
  assign due       = phase_le0 && (count_q < MAX_CNT);
  assign d_fin     = phase_le0 ? PHASE_W'(1) : phase_q;
  assign load      = (st_q == S_RUN) && (&lane_done) && (!out_valid_q || out_ready_i);

  assign lane_req.start = (st_q == S_CHECK) && due;
  assign lane_req.num   = phase_q + outr_s;
  assign lane_req.outr  = outr_q;

  for (genvar c = 0; c < FIELD_CHANNELS; c++) begin : g_lane
    if (c < NUM_LANES) begin : g_on
      lir_lane #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .req_i (lane_req),
        .prev_i(prev_q[c]),
        .cur_i (cur_q[c]),
        .done_o(lane_done[c]),
        .res_o (lane_res[c])
      );
    end else begin : g_off
      assign lane_done[c] = 1'b1;
      assign lane_res[c]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chcnt_q   <= CHCNT_RESET;
      inrate_q  <= RATE_RESET;
      outrate_q <= RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CHANNEL_COUNT: chcnt_q   <= cfg_data_i[CHCNT_W-1:0];
        CFG_INPUT_RATE:    inrate_q  <= cfg_data_i;
        CFG_OUTPUT_RATE:   outrate_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (accept) st_d = S_CHECK;
      end
      S_CHECK: begin
        st_d = due ? S_RUN : S_IDLE;
      end
      S_RUN: begin
        if (load) st_d = S_CHECK;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      phase_q <= '0;
      count_q <= '0;
      for (int c = 0; c < FIELD_CHANNELS; c++) begin
        prev_q[c] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (accept) begin
        count_q <= '0;
      end else if (load) begin
        count_q <= count_q + 1'b1;
        phase_q <= d_next;
      end else if ((st_q == S_CHECK) && !due) begin
        phase_q <= d_fin - outr_s;
        for (int c = 0; c < FIELD_CHANNELS; c++) begin
          prev_q[c] <= cur_q[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inr_q  <= (inrate_q == '0) ? RATE_W'(1) : inrate_q;
      outr_q <= (outrate_q == '0) ? RATE_W'(1) : outrate_q;
      act_q  <= act;
      for (int c = 0; c < FIELD_CHANNELS; c++) begin
        cur_q[c] <= act[c] ? in_ch[c] : '0;
      end
    end
    if ((st_q == S_CHECK) && due) begin
      last_q <= !next_le0 || (count_q == LAST_CNT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_last_q <= last_q;
      for (int c = 0; c < FIELD_CHANNELS; c++) begin
        out_ch_q[c] <= act_q[c] ? lane_res[c] : '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_ch0_o     = out_ch_q[0];
  assign out_ch1_o     = out_ch_q[1];
  assign out_ch2_o     = out_ch_q[2];
  assign out_ch3_o     = out_ch_q[3];
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("Output count exceeds the upsampling limit.");

  a_run_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_RUN) |-> phase_le0)
    else $error("A lane runs while no output position is due.");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_q) |=> ((st_q == S_CHECK) && !due))
    else $error("The last output of a run was not followed by the frame close.");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == S_CHECK) && !due) |=>
      ($signed({phase_q[PHASE_W-1], phase_q}) + $signed({2'b00, outr_q}) > 0))
    else $error("Phase left behind the previous input frame.");
`endif

endmodule

[sim/lir_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler output frame checker
// Watches the register, input and output channels of the resampler. It keeps
// its own copy of the registers, the previous frame and the phase, works out
// the output frames that each accepted input request causes, and compares
// every accepted output frame field by field with the oldest frame still due.
// ----------------------------------------------------------------------------
module lir_frame_checker #(
  parameter int unsigned SW = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [lir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lir_pkg::RATE_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [SW-1:0]                 in_ch0_i,
  input  logic [SW-1:0]                 in_ch1_i,
  input  logic [SW-1:0]                 in_ch2_i,
  input  logic [SW-1:0]                 in_ch3_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [SW-1:0]                 out_ch0_i,
  input  logic [SW-1:0]                 out_ch1_i,
  input  logic [SW-1:0]                 out_ch2_i,
  input  logic [SW-1:0]                 out_ch3_i,
  input  logic                          last_of_run_i,
  output int                            errors_o,
  output int                            pending_o
);
  import lir_pkg::*;

  localparam longint SMP_HI = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMP_LO = -(longint'(1) << (SW - 1));
  localparam int     MAX_REPORTS = 40;

  typedef struct packed {
    logic [FIELD_CHANNELS-1:0][SW-1:0] ch;
    logic                              last;
  } out_frame_t;

  logic [CHCNT_W-1:0]        chan_cnt;
  logic [RATE_W-1:0]         src_rate;
  logic [RATE_W-1:0]         dst_rate;
  logic signed [SW-1:0]      prev_frame [FIELD_CHANNELS];
  logic signed [PHASE_W-1:0] phase;
  out_frame_t                due_frames [$];
  int                        errors;
  int                        pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic longint round_div(longint p, longint q);
    longint mag;
    longint r;
    mag = (p < 0) ? -p : p;
    r   = (mag * 2 + q) / (q * 2);
    return (p < 0) ? -r : r;
  endfunction

  function automatic longint clamp_sample(longint v);
    if (v > SMP_HI) return SMP_HI;
    if (v < SMP_LO) return SMP_LO;
    return v;
  endfunction

  task automatic predict_outputs(input logic [FIELD_CHANNELS-1:0][SW-1:0] frame);
    int         nch;
    int         count;
    longint     inr;
    longint     outr;
    longint     d;
    longint     num;
    longint     v;
    longint     cur [FIELD_CHANNELS];
    out_frame_t f;
    nch = int'(chan_cnt);
    if (nch == 0) nch = 1;
    if (nch > MAX_CHANNELS_DEF) nch = MAX_CHANNELS_DEF;
    if (nch > FIELD_CHANNELS) nch = FIELD_CHANNELS;
    inr  = (src_rate == 0) ? 1 : longint'(src_rate);
    outr = (dst_rate == 0) ? 1 : longint'(dst_rate);
    d    = longint'(phase);
    for (int c = 0; c < FIELD_CHANNELS; c++) begin
      cur[c] = (c < nch) ? longint'($signed(frame[c])) : 0;
    end
    count = 0;
    while (d <= 0 && count < MAX_UPSAMPLE_DEF) begin
      num = d + outr;
      for (int c = 0; c < FIELD_CHANNELS; c++) begin
        v = 0;
        if (c < nch) begin
          v = clamp_sample(longint'(prev_frame[c]) +
                           round_div((cur[c] - longint'(prev_frame[c])) * num, outr));
        end
        f.ch[c] = v[SW-1:0];
      end
      f.last = (d + inr > 0) || (count + 1 == MAX_UPSAMPLE_DEF);
      due_frames.insert(due_frames.size(), f);
      d += inr;
      count++;
    end
    if (d <= 0) d = 1;
    d     = d - outr;
    phase = d[PHASE_W-1:0];
    for (int c = 0; c < FIELD_CHANNELS; c++) begin
      prev_frame[c] = cur[c][SW-1:0];
    end
  endtask

  task automatic check_output();
    out_frame_t want;
    logic [FIELD_CHANNELS-1:0][SW-1:0] got;
    got = {out_ch3_i, out_ch2_i, out_ch1_i, out_ch0_i};
    if (due_frames.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: output frame with none due, ch0 %0d last %0b",
                 $time, $signed(out_ch0_i), last_of_run_i);
      end
      return;
    end
    want = due_frames.pop_front();
    for (int c = 0; c < FIELD_CHANNELS; c++) begin
      if (got[c] !== want.ch[c]) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: out_ch%0d expected %0d, actual %0d",
                   $time, c, $signed(want.ch[c]), $signed(got[c]));
        end
      end
    end
    if (last_of_run_i !== want.last) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: last_of_run expected %0b, actual %0b",
                 $time, want.last, last_of_run_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt = CHCNT_RESET;
      src_rate = RATE_RESET;
      dst_rate = RATE_RESET;
      phase    = '0;
      for (int c = 0; c < FIELD_CHANNELS; c++) prev_frame[c] = '0;
      due_frames.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_outputs({in_ch3_i, in_ch2_i, in_ch1_i, in_ch0_i});
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CHANNEL_COUNT: chan_cnt = cfg_data_i[CHCNT_W-1:0];
          CFG_INPUT_RATE:    src_rate = cfg_data_i;
          CFG_OUTPUT_RATE:   dst_rate = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        check_output();
      end
      pending = due_frames.size();
    end
  end

endmodule

[sim/linear_interp_resampler_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear interpolation resampler testbench
// Drives corner frames and then random frames through the resampler under a
// series of channel counts and rate pairs, including zero and oversized
// register values, the upsampling cap and saturation after a rate change.
// Both channels idle at random outside the steady phase; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit_tb;
  import lir_pkg::*;

  localparam int SW            = SAMPLE_BITS_DEF;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int RUN_ITEMS     = 30;
  localparam int RUN_PHASES    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [SW-1:0] SMP_MAX  = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMP_MIN  = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] SMP_ZERO = '0;
  localparam logic [SW-1:0] SMP_NEG1 = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [SW-1:0]        in_ch0, in_ch1, in_ch2, in_ch3;
  logic                 out_valid;
  logic                 out_ready;
  logic [SW-1:0]        out_ch0, out_ch1, out_ch2, out_ch3;
  logic                 last_of_run;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  bit                   steady = 1'b0;

  linear_interp_resampler_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_ch0_i     (in_ch0),
    .in_ch1_i     (in_ch1),
    .in_ch2_i     (in_ch2),
    .in_ch3_i     (in_ch3),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_ch0_o    (out_ch0),
    .out_ch1_o    (out_ch1),
    .out_ch2_o    (out_ch2),
    .out_ch3_o    (out_ch3),
    .last_of_run_o(last_of_run)
  );

  lir_frame_checker #(.SW(SW)) u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_ch0_i     (in_ch0),
    .in_ch1_i     (in_ch1),
    .in_ch2_i     (in_ch2),
    .in_ch3_i     (in_ch3),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_ch0_i    (out_ch0),
    .out_ch1_i    (out_ch1),
    .out_ch2_i    (out_ch2),
    .out_ch3_i    (out_ch3),
    .last_of_run_i(last_of_run),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    int r;
    int s;
    r = $urandom_range(0, 9);
    if (r < 7) return SW'($urandom);
    if (r < 9) begin
      s = $urandom_range(0, 511) - 256;
      return s[SW-1:0];
    end
    return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
  endfunction

  task automatic send_frame(input logic [SW-1:0] s0, s1, s2, s3);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch0   <= s0;
    in_ch1   <= s1;
    in_ch2   <= s2;
    in_ch3   <= s3;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [CHCNT_W-1:0] ch, input logic [RATE_W-1:0] inr,
                           input logic [RATE_W-1:0] outr);
    settle();
    write_reg(CFG_CHANNEL_COUNT, RATE_W'(ch));
    write_reg(CFG_INPUT_RATE, inr);
    write_reg(CFG_OUTPUT_RATE, outr);
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      int gap;
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    logic [CHCNT_W-1:0] ch;
    logic [RATE_W-1:0]  inr;
    logic [RATE_W-1:0]  outr;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_ch0    = '0;
    in_ch1    = '0;
    in_ch2    = '0;
    in_ch3    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Unity rate, one channel: outputs equal the inputs and idle lanes give zero.
    send_frame(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    send_frame(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);
    send_frame(SMP_ZERO, SMP_NEG1, SMP_MAX, SMP_MIN);
    send_frame(SMP_NEG1, SMP_MAX, SMP_MIN, SMP_NEG1);

    // Oversized channel count, zero input rate, full swing interpolation.
    settle();
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_CHANNEL_COUNT, '1);
    write_reg(CFG_INPUT_RATE, '0);
    write_reg(CFG_OUTPUT_RATE, 19'd3);
    send_frame(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN);
    send_frame(SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX);
    send_frame(SMP_MAX, SMP_MIN, SMP_ZERO, SMP_NEG1);
    send_frame(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555);

    // Upsampling past the cap, then a sharp drop of the output rate.
    configure(3'd0, 19'd1, 19'd384000);
    send_frame(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX);
    configure(3'd0, 19'd1, 19'd1);
    send_frame(SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN);

    // Deep downsampling: frames after the first cause no output.
    configure(3'd2, '1, 19'd1);
    send_frame(SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN);
    send_frame(SMP_ZERO, SMP_NEG1, SMP_ZERO, SMP_NEG1);
    send_frame(SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX);

    for (int p = 0; p < RUN_PHASES; p++) begin
      case (p)
        0: begin ch = 3'd4; inr = 19'd44100; outr = 19'd48000; end
        1: begin ch = 3'd2; inr = 19'd48000; outr = 19'd44100; end
        2: begin ch = 3'd3; inr = 19'd8000;  outr = 19'd96000; end
        3: begin ch = 3'd1; inr = 19'd96000; outr = 19'd48000; end
        default: begin
          ch   = CHCNT_W'($urandom_range(0, 7));
          inr  = RATE_W'($urandom_range(8000, 384000));
          outr = RATE_W'($urandom_range(8000, 384000));
        end
      endcase
      configure(ch, inr, outr);
      steady = (p == 1);
      repeat (RUN_ITEMS) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
      steady = 1'b0;
    end

    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/lir_pkg.sv
hw/rtl/lir_lane.sv
hw/rtl/linear_interp_resampler_unit.sv
sim/lir_frame_checker.sv
sim/linear_interp_resampler_unit_tb.sv
